// ===== src/pnms_pkg.sv =====
package pnms_pkg;

    localparam int INDEX_BITS   = 16;
    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int W_BITS       = 10;
    localparam int K_BITS       = 8;
    localparam int MAX_NET_SIZE = 255;
    localparam int NUM_BITS     = W_BITS + K_BITS + FRAC_BITS;
    localparam int G_BITS       = NUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(NUM_BITS);
    localparam int Q_BITS       = 32;
    localparam int D_BITS       = 48;
    localparam int PROD_BITS    = G_BITS + COORD_BITS;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [G_BITS-1:0]    Q_MAX   = G_BITS'(32'h7FFF_FFFF);
    localparam logic [PROD_BITS-1:0] D_LIMIT = PROD_BITS'(1) << (D_BITS - 1);

    typedef enum logic [1:0] {KIND_NONE, KIND_CELL, KIND_PIN} t_kind;
    typedef enum logic {REG_NUM_MOVABLE, REG_NUM_TOTAL} t_reg_idx;
    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_front_state;
    typedef enum logic [1:0] {B_IDLE, B_MUL, B_EMIT} t_back_state;

    typedef struct packed {
        t_kind                  kind;
        logic [INDEX_BITS-1:0]  row;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
    } t_node;

    typedef struct packed {
        logic                   cc;
        logic [INDEX_BITS-1:0]  row_a;
        logic [INDEX_BITS-1:0]  row_b;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [G_BITS-1:0]      g;
        logic                   last;
    } t_conn;

    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] num;
        logic [K_BITS-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [G_BITS-1:0] quot;
    } t_div_rsp;

    function automatic t_node make_node(input logic [INDEX_BITS-1:0] idx,
                                        input logic [COORD_BITS-1:0] x,
                                        input logic [COORD_BITS-1:0] y,
                                        input logic [INDEX_BITS-1:0] nmc,
                                        input logic [INDEX_BITS-1:0] ntot);
        t_node n;
        n.row = idx;
        n.x   = x;
        n.y   = y;
        if (idx < nmc) n.kind = KIND_CELL;
        else if (idx < ntot) n.kind = KIND_PIN;
        else n.kind = KIND_NONE;
        return n;
    endfunction

endpackage

// ===== src/pnms_if.sv =====
interface pnms_in_if;
    import pnms_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] node_index;
    logic [COORD_BITS-1:0] node_x;
    logic [COORD_BITS-1:0] node_y;
    logic [W_BITS-1:0]     net_weight;
    logic [K_BITS-1:0]     net_size;
    modport source (output valid, node_index, node_x, node_y, net_weight, net_size,
                    input ready);
    modport sink (input valid, node_index, node_x, node_y, net_weight, net_size,
                  output ready);
endinterface

interface pnms_out_if;
    import pnms_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [INDEX_BITS-1:0]    row_index;
    logic [INDEX_BITS-1:0]    col_index;
    logic signed [Q_BITS-1:0] q_delta;
    logic signed [D_BITS-1:0] dx_delta;
    logic signed [D_BITS-1:0] dy_delta;
    logic                     last_stamp;
    modport source (output valid, row_index, col_index, q_delta, dx_delta, dy_delta,
                    last_stamp, input ready);
    modport sink (input valid, row_index, col_index, q_delta, dx_delta, dy_delta,
                  last_stamp, output ready);
endinterface

// ===== src/pnms_div.sv =====
module pnms_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pnms_pkg::t_div_req i_req,
    output pnms_pkg::t_div_rsp o_rsp
);
    import pnms_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0]     r_num;
    logic [K_BITS-1:0]       r_rem;
    logic [K_BITS-1:0]       r_den;
    logic [G_BITS-1:0]       r_quot;
    logic [K_BITS:0]         trial;
    logic [K_BITS:0]         diff;
    logic                    ge;

    // one quotient bit a cycle, restoring
    always_comb begin
        trial = {r_rem, r_num[NUM_BITS-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[K_BITS-1:0] : trial[K_BITS-1:0];
            r_num  <= {r_num[NUM_BITS-2:0], 1'b0};
            r_quot <= {r_quot[G_BITS-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== src/pnms_front.sv =====
module pnms_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pnms_in_if.sink                           i_in,
    input  logic [pnms_pkg::INDEX_BITS-1:0]   i_num_movable,
    input  logic [pnms_pkg::INDEX_BITS-1:0]   i_num_total,
    output pnms_pkg::t_conn                   o_push_data,
    output logic                              o_push_valid,
    input  logic                              i_push_ready,
    output pnms_pkg::t_div_req                o_div_req,
    input  pnms_pkg::t_div_rsp                i_div_rsp
);
    import pnms_pkg::*;

    t_front_state          r_state, n_state;
    logic [K_BITS-1:0]     r_count;
    logic [INDEX_BITS-1:0] r_star;
    logic [INDEX_BITS-1:0] r_held_node [0:1];
    logic [COORD_BITS-1:0] r_held_x [0:1];
    logic [COORD_BITS-1:0] r_held_y [0:1];
    t_node                 r_a [0:2];
    t_node                 r_b [0:2];
    logic [2:0]            r_use;
    logic [1:0]            r_ci;
    logic [G_BITS-1:0]     r_g;
    logic                  r_cv;
    logic [W_BITS-1:0]     r_cw;
    logic [K_BITS-1:0]     r_ck;
    logic [G_BITS-1:0]     r_cg;
    logic [W_BITS-1:0]     r_iw;
    logic [K_BITS-1:0]     r_ik;
    logic                  r_div_start;
    logic [NUM_BITS-1:0]   r_num;
    logic [K_BITS-1:0]     r_den;

    logic [K_BITS-1:0]        k;
    logic [W_BITS-1:0]        w;
    logic                     accept, drop, last, star, clique_go, hit, advance, slot_last;
    t_node                    cur, h0, h1, star_node, a0, b0;
    logic [2:0]               use_n;
    logic [K_BITS-1:0]        den, fac;
    logic [W_BITS+K_BITS-1:0] prod;
    logic [NUM_BITS-1:0]      num;
    t_node                    sa, sb;

    function automatic logic live(input t_node a, input t_node b);
        return a.kind != KIND_NONE && b.kind != KIND_NONE
            && !(a.kind == KIND_PIN && b.kind == KIND_PIN);
    endfunction

    always_comb begin
        k      = i_in.net_size;
        w      = i_in.net_weight;
        accept = i_in.valid && i_in.ready;
        drop   = (k < K_BITS'(2)) || (int'(k) > MAX_NET_SIZE);
        last   = ({1'b0, r_count} + (K_BITS+1)'(1)) >= {1'b0, k};
        star   = k > K_BITS'(3);
        cur    = make_node(i_in.node_index, i_in.node_x, i_in.node_y,
                           i_num_movable, i_num_total);
        h0     = make_node(r_held_node[0], r_held_x[0], r_held_y[0],
                           i_num_movable, i_num_total);
        h1     = make_node(r_held_node[1], r_held_x[1], r_held_y[1],
                           i_num_movable, i_num_total);
        star_node.kind = KIND_CELL;
        star_node.row  = i_num_movable + r_star;
        star_node.x    = '0;
        star_node.y    = '0;
        clique_go = !star && last && (r_count != '0);
        a0 = star ? cur : h0;
        b0 = star ? star_node : ((k == K_BITS'(2)) ? cur : h1);
        use_n[0] = (star || clique_go) && live(a0, b0);
        use_n[1] = clique_go && (k == K_BITS'(3)) && live(h1, cur);
        use_n[2] = clique_go && (k == K_BITS'(3)) && live(h0, cur);
        den  = k - K_BITS'(1);
        fac  = star ? k : K_BITS'(1);
        prod = (W_BITS+K_BITS)'(w) * (W_BITS+K_BITS)'(fac);
        num  = {prod, FRAC_BITS'(0)} + NUM_BITS'(den >> 1);
        hit  = r_cv && (r_cw == w) && (r_ck == k);
    end

    // push one connection a cycle unless the queue is full, skipping empty slots
    always_comb begin
        sa = r_a[r_ci];
        sb = r_b[r_ci];
        case (r_ci)
            2'd0:    slot_last = !r_use[1] && !r_use[2];
            2'd1:    slot_last = !r_use[2];
            default: slot_last = 1'b1;
        endcase
        o_push_data.g    = r_g;
        o_push_data.last = slot_last;
        o_push_data.row_b = sb.row;
        if (sa.kind == KIND_PIN) begin
            o_push_data.cc    = 1'b0;
            o_push_data.row_a = sb.row;
            o_push_data.x     = sa.x;
            o_push_data.y     = sa.y;
        end else if (sb.kind == KIND_PIN) begin
            o_push_data.cc    = 1'b0;
            o_push_data.row_a = sa.row;
            o_push_data.x     = sb.x;
            o_push_data.y     = sb.y;
        end else begin
            o_push_data.cc    = 1'b1;
            o_push_data.row_a = sa.row;
            o_push_data.x     = '0;
            o_push_data.y     = '0;
        end
        o_push_valid = (r_state == F_PUSH) && r_use[r_ci];
        advance      = !r_use[r_ci] || i_push_ready;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept && !drop && (use_n != '0)) n_state = hit ? F_PUSH : F_DIV;
            end
            F_DIV: begin
                if (i_div_rsp.done) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (advance && r_ci == 2'd2) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == F_IDLE);
    assign o_div_req.start = r_div_start;
    assign o_div_req.num   = r_num;
    assign o_div_req.den   = r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_count     <= '0;
            r_star      <= '0;
            r_cv        <= 1'b0;
            r_div_start <= 1'b0;
            r_ci        <= '0;
        end else begin
            r_state     <= n_state;
            r_div_start <= 1'b0;
            if (accept) begin
                if (drop) begin
                    r_count <= '0;
                end else begin
                    r_count <= last ? '0 : r_count + 1'b1;
                    if (star && last) r_star <= r_star + 1'b1;
                    r_ci <= '0;
                    if (!hit && use_n != '0) r_div_start <= 1'b1;
                end
            end
            if (r_state == F_DIV && i_div_rsp.done) r_cv <= 1'b1;
            if (r_state == F_PUSH && advance) r_ci <= (r_ci == 2'd2) ? 2'd0 : r_ci + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !drop) begin
            if (r_count < K_BITS'(2)) begin
                r_held_node[r_count[0]] <= i_in.node_index;
                r_held_x[r_count[0]]    <= i_in.node_x;
                r_held_y[r_count[0]]    <= i_in.node_y;
            end
            r_a[0] <= a0;  r_b[0] <= b0;
            r_a[1] <= h1;  r_b[1] <= cur;
            r_a[2] <= h0;  r_b[2] <= cur;
            r_use  <= use_n;
            r_iw   <= w;
            r_ik   <= k;
            r_num  <= num;
            r_den  <= den;
            if (hit) r_g <= r_cg;
        end
        if (r_state == F_DIV && i_div_rsp.done) begin
            r_g  <= i_div_rsp.quot;
            r_cg <= i_div_rsp.quot;
            r_cw <= r_iw;
            r_ck <= r_ik;
        end
    end

endmodule

// ===== src/pnms_queue.sv =====
module pnms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pnms_pkg::t_conn i_push_data,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    output pnms_pkg::t_conn o_pop_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready
);
    import pnms_pkg::*;

    t_conn                r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_BITS-1:0] r_wp, r_rp;
    logic [QPTR_BITS:0]   r_cnt;
    logic                 push, pop;

    assign o_push_ready = r_cnt != (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rp];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push_data;
    end

endmodule

// ===== src/pnms_back.sv =====
module pnms_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pnms_pkg::t_conn i_pop_data,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    pnms_out_if.source      o_out
);
    import pnms_pkg::*;

    t_back_state            r_state, n_state;
    t_conn                  r_cmd;
    logic [PROD_BITS-1:0]   r_px, r_py;
    logic [1:0]             r_st;
    logic                   r_ov;
    logic [INDEX_BITS-1:0]  r_row, r_col;
    logic [Q_BITS-1:0]      r_q;
    logic [D_BITS-1:0]      r_dx, r_dy;
    logic                   r_last;

    logic                   load, final_step;
    logic [Q_BITS-1:0]      q, nq;
    logic [D_BITS-1:0]      ndx, ndy;
    logic [INDEX_BITS-1:0]  s_row, s_col;
    logic [Q_BITS-1:0]      s_q;

    always_comb begin
        q   = (r_cmd.g > Q_MAX) ? Q_MAX[Q_BITS-1:0] : r_cmd.g[Q_BITS-1:0];
        nq  = -q;
        ndx = -((r_px > D_LIMIT) ? D_LIMIT[D_BITS-1:0] : r_px[D_BITS-1:0]);
        ndy = -((r_py > D_LIMIT) ? D_LIMIT[D_BITS-1:0] : r_py[D_BITS-1:0]);
        final_step = !r_cmd.cc || (r_st == 2'd3);
        load = (r_state == B_EMIT) && (!r_ov || o_out.ready);
        case (r_st)
            2'd0:    begin s_row = r_cmd.row_a; s_col = r_cmd.row_a; s_q = q;  end
            2'd1:    begin s_row = r_cmd.row_b; s_col = r_cmd.row_b; s_q = q;  end
            2'd2:    begin s_row = r_cmd.row_a; s_col = r_cmd.row_b; s_q = nq; end
            default: begin s_row = r_cmd.row_b; s_col = r_cmd.row_a; s_q = nq; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (i_pop_valid) n_state = B_MUL;
            B_MUL:   n_state = B_EMIT;
            B_EMIT:  if (load && final_step) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    assign o_pop_ready = (r_state == B_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_pop_valid) r_cmd <= i_pop_data;
        if (r_state == B_MUL) begin
            r_px <= PROD_BITS'(r_cmd.g) * PROD_BITS'(r_cmd.x);
            r_py <= PROD_BITS'(r_cmd.g) * PROD_BITS'(r_cmd.y);
            r_st <= '0;
        end
        if (load) begin
            r_st   <= r_st + 1'b1;
            r_last <= r_cmd.last && final_step;
            if (r_cmd.cc) begin
                r_row <= s_row;
                r_col <= s_col;
                r_q   <= s_q;
                r_dx  <= '0;
                r_dy  <= '0;
            end else begin
                r_row <= r_cmd.row_a;
                r_col <= r_cmd.row_a;
                r_q   <= q;
                r_dx  <= ndx;
                r_dy  <= ndy;
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.row_index  = r_row;
    assign o_out.col_index  = r_col;
    assign o_out.q_delta    = r_q;
    assign o_out.dx_delta   = r_dx;
    assign o_out.dy_delta   = r_dy;
    assign o_out.last_stamp = r_last;

endmodule

// ===== src/placement_net_model_stamper_core.sv =====
// Net stamper for quadratic placement, clique and star net models.
// i_in takes one net member per request (node index, pin position, net weight
// and net size); o_out gives the matrix stamps it causes (row, column, Q, dx,
// dy), last_stamp marking the final stamp of that member.  Both channels move
// a request when valid and ready are high at a rising edge.  The APB port sets
// the movable cell count (address 0) and the cell plus pin count (address 4);
// write these only while the block is idle.
// A member is taken only while the front is idle; the front then runs the
// bit-serial weight division (start, 34 quotient bits, result) when weight
// or size differs from the last divided pair, and steps through the three
// connection slots in turn.  The back loads each connection, multiplies,
// then emits its stamps (one for a pin connection, four for two cells).
// Net members of the same net share the division.  A four-entry connection
// queue parts front and back; a stalled receiver holds o_out and fills the
// queue, after which i_in.ready drops.  On a divider hit the front skips the
// division and goes straight to pushing connections.
// Synchronous reset clears the net framing, star count, divider cache, queue
// and output valid; registers read back as zero.
module placement_net_model_stamper_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pnms_in_if.sink                             i_in,
    pnms_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pnms_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [pnms_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [pnms_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import pnms_pkg::*;

    logic [INDEX_BITS-1:0] r_num_movable, r_num_total;
    t_reg_idx              reg_sel;
    t_conn                 push_data, pop_data;
    logic                  push_valid, push_ready, pop_valid, pop_ready;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_movable <= '0;
            r_num_total   <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_NUM_MOVABLE: r_num_movable <= pwdata[INDEX_BITS-1:0];
                REG_NUM_TOTAL:   r_num_total   <= pwdata[INDEX_BITS-1:0];
                default:         r_num_total   <= r_num_total;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_NUM_MOVABLE: prdata = APB_DATA_BITS'(r_num_movable);
            REG_NUM_TOTAL:   prdata = APB_DATA_BITS'(r_num_total);
            default:         prdata = '0;
        endcase
    end

    pnms_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_num_movable (r_num_movable),
        .i_num_total   (r_num_total),
        .o_push_data   (push_data),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp)
    );

    pnms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    pnms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (push_data),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_pop_data   (pop_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    pnms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_data  (pop_data),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

// ===== src/pnms_checker.sv =====
module pnms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_row,
    input logic [15:0] i_col,
    input logic [31:0] i_q,
    input logic [47:0] i_dx,
    input logic        i_last,
    input logic        i_pready
);

    // stalled stamp holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_row) && $stable(i_col)
            && $stable(i_q) && $stable(i_last))
        else $error("stalled stamp changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("stamp valid after reset");

    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");

    // pin stamps land on the diagonal only
    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dx != 48'd0 |-> i_row == i_col)
        else $error("dx stamp off diagonal");

endmodule

bind placement_net_model_stamper_core pnms_checker u_pnms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_row       (o_out.row_index),
    .i_col       (o_out.col_index),
    .i_q         (o_out.q_delta),
    .i_dx        (o_out.dx_delta),
    .i_last      (o_out.last_stamp),
    .i_pready    (pready)
);
